@@ rtl/slcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// Shared types and constants of the sync/length/checksum deframer.
// ----------------------------------------------------------------------------
package slcd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned QDepth  = 2;

  localparam logic [CfgIdxW-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ERROR_LIMIT = 2'd2;

  localparam logic [ByteW-1:0] SYNC_FIRST_RST  = 8'hAA;
  localparam logic [ByteW-1:0] SYNC_SECOND_RST = 8'h55;
  localparam logic [ByteW-1:0] ERROR_LIMIT_RST = 8'd10;
  localparam logic [ByteW-1:0] COUNT_MAX       = 8'd255;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_MISMATCH = 2'd1,
    ST_ZEROLEN  = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] sync_first;
    logic [ByteW-1:0] sync_second;
    logic [ByteW-1:0] error_limit;
  } cfg_t;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             is_end;
    logic             is_cmd;
    status_e          status;
  } event_t;

endpackage

@@ rtl/slcd_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_in_if
// Received byte channel: valid/ready handshake carrying one byte per item.
// ----------------------------------------------------------------------------
interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

@@ rtl/slcd_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_out_if
// Result channel: forwarded payload bytes and frame verdicts.
// ----------------------------------------------------------------------------
interface slcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_frame_end;
  logic       is_command_id;
  logic [1:0] frame_status;
  logic       error_alarm;
  logic [7:0] error_count;

  modport source (
    output valid, output out_byte, output is_frame_end, output is_command_id,
    output frame_status, output error_alarm, output error_count, input ready
  );
  modport sink (
    input valid, input out_byte, input is_frame_end, input is_command_id,
    input frame_status, input error_alarm, input error_count, output ready
  );
endinterface

@@ rtl/sync_length_checksum_deframer.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer
// Serial frame deframer with sync hunt, length byte and additive checksum.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle while the event queue is not full, and
// returns at most one result per byte: each payload byte as it arrives (first
// one flagged as command id) and one verdict at the checksum byte or a zero
// length byte. The parser classifies a byte within the accepting cycle and
// writes its event into the queue; the verdict stage moves it into the output
// register once that register is empty or being taken. Input ready drops only
// when the two-entry event queue between them is full, that is after the
// result side has stalled. The user must write the configuration registers
// only while the block is idle; the block itself does not enforce this.
module sync_length_checksum_deframer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  slcd_in_if.sink                      in_if,
  slcd_out_if.source                   out_if,
  input  logic                         cfg_we_i,
  input  logic [slcd_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [slcd_pkg::ByteW-1:0]   cfg_data_i
);

  slcd_pkg::cfg_t   cfg_q;
  slcd_pkg::event_t front_ev, queue_ev;
  logic             front_push, queue_full, queue_valid, back_pop, take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sync_first  <= slcd_pkg::SYNC_FIRST_RST;
      cfg_q.sync_second <= slcd_pkg::SYNC_SECOND_RST;
      cfg_q.error_limit <= slcd_pkg::ERROR_LIMIT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        slcd_pkg::CFG_SYNC_FIRST:  cfg_q.sync_first  <= cfg_data_i;
        slcd_pkg::CFG_SYNC_SECOND: cfg_q.sync_second <= cfg_data_i;
        slcd_pkg::CFG_ERROR_LIMIT: cfg_q.error_limit <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_if.ready = !queue_full;
  assign take        = in_if.valid && !queue_full;

  slcd_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_q),
    .take_i (take),
    .byte_i (in_if.rx_byte),
    .push_o (front_push),
    .ev_o   (front_ev)
  );

  slcd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (front_push),
    .ev_i    (front_ev),
    .full_o  (queue_full),
    .pop_i   (back_pop),
    .valid_o (queue_valid),
    .ev_o    (queue_ev)
  );

  slcd_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .limit_i    (cfg_q.error_limit),
    .ev_valid_i (queue_valid),
    .ev_i       (queue_ev),
    .pop_o      (back_pop),
    .out_if     (out_if)
  );

endmodule

@@ rtl/slcd_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_front
// Frame parser: hunts for sync, tracks length and checksum, emits events.
// ----------------------------------------------------------------------------
module slcd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  slcd_pkg::cfg_t                cfg_i,
  input  logic                          take_i,
  input  logic [slcd_pkg::ByteW-1:0]    byte_i,
  output logic                          push_o,
  output slcd_pkg::event_t              ev_o
);

  typedef enum logic [2:0] {
    PH_HUNT1   = 3'd0,
    PH_HUNT2   = 3'd1,
    PH_LENGTH  = 3'd2,
    PH_PAYLOAD = 3'd3,
    PH_CHECK   = 3'd4
  } phase_e;

  phase_e                    phase_q, phase_d;
  logic [slcd_pkg::ByteW-1:0] left_q, left_d;
  logic [slcd_pkg::ByteW-1:0] sum_q, sum_d;
  logic                      first_q, first_d;
  logic [slcd_pkg::ByteW-1:0] left_dec;

  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d   = phase_q;
    left_d    = left_q;
    sum_d     = sum_q;
    first_d   = first_q;
    push_o    = 1'b0;
    ev_o      = '0;
    ev_o.data = byte_i;
    if (take_i) begin
      case (phase_q)
        PH_HUNT2: begin
          if (byte_i == cfg_i.sync_second) begin
            phase_d = PH_LENGTH;
          end else if (byte_i != cfg_i.sync_first) begin
            phase_d = PH_HUNT1;
          end
        end
        PH_LENGTH: begin
          if (byte_i == '0) begin
            push_o      = 1'b1;
            ev_o.data   = '0;
            ev_o.is_end = 1'b1;
            ev_o.status = slcd_pkg::ST_ZEROLEN;
            phase_d     = PH_HUNT1;
          end else begin
            left_d  = byte_i;
            sum_d   = byte_i;
            first_d = 1'b1;
            phase_d = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          push_o      = 1'b1;
          ev_o.is_cmd = first_q;
          first_d     = 1'b0;
          sum_d       = sum_q + byte_i;
          left_d      = left_dec;
          if (left_dec == '0) begin
            phase_d = PH_CHECK;
          end
        end
        PH_CHECK: begin
          push_o      = 1'b1;
          ev_o.data   = '0;
          ev_o.is_end = 1'b1;
          ev_o.status = (byte_i == sum_q) ? slcd_pkg::ST_GOOD : slcd_pkg::ST_MISMATCH;
          phase_d     = PH_HUNT1;
        end
        default: begin
          phase_d = (byte_i == cfg_i.sync_first) ? PH_HUNT2 : PH_HUNT1;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT1;
      left_q  <= '0;
      sum_q   <= '0;
      first_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      left_q  <= left_d;
      sum_q   <= sum_d;
      first_q <= first_d;
    end
  end

endmodule

@@ rtl/slcd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_queue
// Short event queue between the parser and the verdict stage.
// ----------------------------------------------------------------------------
module slcd_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  slcd_pkg::event_t ev_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output slcd_pkg::event_t ev_o
);

  localparam int unsigned PtrW = (slcd_pkg::QDepth > 1) ? $clog2(slcd_pkg::QDepth) : 1;
  localparam int unsigned CntW = $clog2(slcd_pkg::QDepth + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(slcd_pkg::QDepth);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(slcd_pkg::QDepth - 1);

  slcd_pkg::event_t      mem_q [slcd_pkg::QDepth];
  logic [PtrW-1:0]       wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign valid_o = (cnt_q != '0);
  assign ev_o    = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= ev_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

@@ rtl/slcd_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_back
// Verdict stage: tracks consecutive errors, raises the alarm, drives results.
// ----------------------------------------------------------------------------
module slcd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [slcd_pkg::ByteW-1:0] limit_i,
  input  logic                       ev_valid_i,
  input  slcd_pkg::event_t           ev_i,
  output logic                       pop_o,
  slcd_out_if.source                 out_if
);

  logic                       valid_q, valid_d;
  slcd_pkg::event_t           res_q, res_d;
  logic                       alarm_q, alarm_d;
  logic [slcd_pkg::ByteW-1:0] errs_q, errs_d;
  logic [slcd_pkg::ByteW-1:0] errs_upd;

  assign pop_o = ev_valid_i && (!valid_q || out_if.ready);

  always_comb begin
    errs_upd = errs_q;
    if (ev_i.status == slcd_pkg::ST_GOOD) begin
      errs_upd = '0;
    end else if (errs_q != slcd_pkg::COUNT_MAX) begin
      errs_upd = errs_q + 8'd1;
    end
  end

  always_comb begin
    valid_d = valid_q;
    res_d   = res_q;
    alarm_d = alarm_q;
    errs_d  = errs_q;
    if (valid_q && out_if.ready) begin
      valid_d = 1'b0;
    end
    if (pop_o) begin
      valid_d = 1'b1;
      res_d   = ev_i;
      alarm_d = 1'b0;
      if (ev_i.is_end) begin
        if (errs_upd > limit_i) begin
          alarm_d = 1'b1;
          errs_d  = '0;
        end else begin
          errs_d = errs_upd;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      errs_q  <= '0;
    end else begin
      valid_q <= valid_d;
      errs_q  <= errs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q   <= res_d;
    alarm_q <= alarm_d;
  end

  assign out_if.valid         = valid_q;
  assign out_if.out_byte      = res_q.data;
  assign out_if.is_frame_end  = res_q.is_end;
  assign out_if.is_command_id = res_q.is_cmd;
  assign out_if.frame_status  = res_q.status;
  assign out_if.error_alarm   = alarm_q;
  assign out_if.error_count   = errs_q;

endmodule
